@@ sv/qcn_pkg.sv @@
package qcn_pkg;

  localparam int COORD_WIDTH     = 12;
  localparam int NORMAL_FRACTION = 14;

  // edge, product, cross, magnitude, square, sum, root, quotient, output widths
  localparam int EW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * EW;
  localparam int XW  = PW + 1;
  localparam int MW  = 2 * COORD_WIDTH + 1;
  localparam int SQW = 2 * MW;
  localparam int SW  = 2 * MW + 2;
  localparam int RW  = MW + 1;
  localparam int QW  = NORMAL_FRACTION + 1;
  localparam int OW  = NORMAL_FRACTION + 2;

  localparam int FRONT_STAGES = 5;
  localparam int LATENCY      = FRONT_STAGES + RW + NORMAL_FRACTION + 2;
  localparam int UNIT         = 1 << NORMAL_FRACTION;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OW-1:0]          ncomp_t;
  typedef logic [SW-1:0]                 sum_t;

  // one corner handed from the front end to the normaliser
  typedef struct packed {
    sum_t               sum;
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
  } corner_t;

endpackage

@@ sv/qcn_quad_if.sv @@
interface qcn_quad_if;
  import qcn_pkg::*;

  logic   valid;
  logic   ready;
  coord_t c0_x, c0_y, c0_z;
  coord_t c1_x, c1_y, c1_z;
  coord_t c2_x, c2_y, c2_z;
  coord_t c3_x, c3_y, c3_z;

  modport source (
    output valid, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z,
           c2_x, c2_y, c2_z, c3_x, c3_y, c3_z,
    input  ready
  );
  modport sink (
    input  valid, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z,
           c2_x, c2_y, c2_z, c3_x, c3_y, c3_z,
    output ready
  );
endinterface

@@ sv/qcn_normal_if.sv @@
interface qcn_normal_if;
  import qcn_pkg::*;

  logic   valid;
  logic   ready;
  ncomp_t n0_x, n0_y, n0_z;
  ncomp_t n1_x, n1_y, n1_z;
  ncomp_t n2_x, n2_y, n2_z;
  ncomp_t n3_x, n3_y, n3_z;

  modport source (
    output valid, n0_x, n0_y, n0_z, n1_x, n1_y, n1_z,
           n2_x, n2_y, n2_z, n3_x, n3_y, n3_z,
    input  ready
  );
  modport sink (
    input  valid, n0_x, n0_y, n0_z, n1_x, n1_y, n1_z,
           n2_x, n2_y, n2_z, n3_x, n3_y, n3_z,
    output ready
  );
endinterface

@@ sv/qcn_norm.sv @@
// Pipelined normaliser: one root bit per stage, then one quotient bit per stage.
module qcn_norm (
  input  logic                                  clk,
  input  logic                                  en,
  input  qcn_pkg::corner_t                      corner,
  output logic [2:0][qcn_pkg::OW-1:0]           nrm
);
  import qcn_pkg::*;

  typedef struct packed {
    sum_t               s;
    logic [RW+1:0]      rem;
    logic [RW-1:0]      root;
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
  } sq_t;

  typedef struct packed {
    logic [RW-1:0]      m;
    logic               mz;
    logic [2:0][RW-1:0] r;
    logic [2:0][QW-1:0] q;
    logic [2:0]         neg;
  } dv_t;

  function automatic sq_t sqrt_step(sq_t a);
    sq_t           r;
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    r     = a;
    cur   = {a.rem, a.s[SW-1 -: 2]};
    trial = {2'b00, a.root, 2'b01};
    diff  = cur - trial;
    if (cur >= trial) begin
      r.rem  = diff[RW+1:0];
      r.root = {a.root[RW-2:0], 1'b1};
    end else begin
      r.rem  = cur[RW+1:0];
      r.root = {a.root[RW-2:0], 1'b0};
    end
    r.s = {a.s[SW-3:0], 2'b00};
    return r;
  endfunction

  function automatic dv_t div_step(dv_t a);
    dv_t         r;
    logic [RW:0] t;
    logic [RW:0] mm;
    logic [RW:0] d;
    r  = a;
    mm = {1'b0, a.m};
    for (int j = 0; j < 3; j++) begin
      t = {a.r[j], 1'b0};
      d = t - mm;
      if (t >= mm) begin
        r.r[j] = d[RW-1:0];
        r.q[j] = {a.q[j][QW-2:0], 1'b1};
      end else begin
        r.r[j] = t[RW-1:0];
        r.q[j] = {a.q[j][QW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  sq_t sq_in;
  sq_t sq_q [RW];
  dv_t dv_in;
  dv_t dv_q [NORMAL_FRACTION+1];

  always_comb begin
    sq_in.s    = corner.sum;
    sq_in.rem  = '0;
    sq_in.root = '0;
    sq_in.mag  = corner.mag;
    sq_in.neg  = corner.neg;
  end

  // integer part: |c| <= m so the leading quotient bit is 0 or 1
  always_comb begin
    logic [RW-1:0] magx;
    logic          ge;
    dv_in.m   = sq_q[RW-1].root;
    dv_in.mz  = (sq_q[RW-1].root == '0);
    dv_in.neg = sq_q[RW-1].neg;
    for (int j = 0; j < 3; j++) begin
      magx       = RW'(sq_q[RW-1].mag[j]);
      ge         = (magx >= sq_q[RW-1].root);
      dv_in.r[j] = ge ? magx - sq_q[RW-1].root : magx;
      dv_in.q[j] = {{(QW-1){1'b0}}, ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_q[0] <= sqrt_step(sq_in);
      for (int k = 1; k < RW; k++) begin
        sq_q[k] <= sqrt_step(sq_q[k-1]);
      end
      dv_q[0] <= dv_in;
      for (int k = 1; k <= NORMAL_FRACTION; k++) begin
        dv_q[k] <= div_step(dv_q[k-1]);
      end
      for (int j = 0; j < 3; j++) begin
        if (dv_q[NORMAL_FRACTION].mz) begin
          nrm[j] <= '0;
        end else if (dv_q[NORMAL_FRACTION].neg[j]) begin
          nrm[j] <= OW'(0) - OW'(dv_q[NORMAL_FRACTION].q[j]);
        end else begin
          nrm[j] <= OW'(dv_q[NORMAL_FRACTION].q[j]);
        end
      end
    end
  end

endmodule

@@ sv/quad_corner_normals_core.sv @@
// Per-corner unit normals of a quad.
// quad   (sink):   one transaction carries the four corners, signed 12-bit coordinates.
// normal (source): one transaction carries four normals, signed Q1.14 per component,
//                  in the order the quads were taken.
// Each corner normal is the cross product of its two ring edges, divided by the
// floor square root of its squared length; quotients truncate toward zero and a
// zero-length cross product gives a zero normal.
// Throughput: one quad per cycle while the receiver does not stall. The pipeline has
// 5 front stages for edges, products, cross, squares and sum, one stage per root bit
// (26), one per quotient bit (15) and one output stage.
// The whole pipeline advances together; when the receiver holds ready low with a
// result waiting, every stage holds and quad.ready drops in the same cycle, so
// nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Reset (rst, synchronous, active high) clears the valid bits only; there is no
// other state and no start-up pass.
module quad_corner_normals_core (
  input logic          clk,
  input logic          rst,
  qcn_quad_if.sink     quad,
  qcn_normal_if.source normal
);
  import qcn_pkg::*;

  logic [LATENCY-1:0] vld;
  logic               en;

  coord_t p [4][3];

  logic signed [EW-1:0] u_q  [4][3];
  logic signed [EW-1:0] v_q  [4][3];
  logic signed [PW-1:0] pa_q [4][3];
  logic signed [PW-1:0] pb_q [4][3];
  logic [2:0][MW-1:0]   mag3_q [4];
  logic [2:0]           neg3_q [4];
  logic [SQW-1:0]       sqr_q  [4][3];
  logic [2:0][MW-1:0]   mag4_q [4];
  logic [2:0]           neg4_q [4];
  corner_t              cn_q   [4];
  logic [2:0][OW-1:0]   nrm    [4];

  // whole pipe moves unless the output register is full and stalled
  assign en           = !vld[LATENCY-1] || normal.ready;
  assign quad.ready   = en;
  assign normal.valid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], quad.valid};
    end
  end

  always_comb begin
    p[0][0] = quad.c0_x; p[0][1] = quad.c0_y; p[0][2] = quad.c0_z;
    p[1][0] = quad.c1_x; p[1][1] = quad.c1_y; p[1][2] = quad.c1_z;
    p[2][0] = quad.c2_x; p[2][1] = quad.c2_y; p[2][2] = quad.c2_z;
    p[3][0] = quad.c3_x; p[3][1] = quad.c3_y; p[3][2] = quad.c3_z;
  end

  // stages 1 and 2: ring edges, then the six cross-product terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          u_q[i][k]  <= EW'(p[(i+1)%4][k]) - EW'(p[i][k]);
          v_q[i][k]  <= EW'(p[(i+3)%4][k]) - EW'(p[i][k]);
          pa_q[i][k] <= PW'(u_q[i][(k+1)%3]) * PW'(v_q[i][(k+2)%3]);
          pb_q[i][k] <= PW'(u_q[i][(k+2)%3]) * PW'(v_q[i][(k+1)%3]);
        end
      end
    end
  end

  // stages 3 to 5: cross component to sign and magnitude, squares, sum
  always_ff @(posedge clk) begin
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] ax;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          x  = XW'(pa_q[i][k]) - XW'(pb_q[i][k]);
          ax = (x < 0) ? -x : x;
          mag3_q[i][k] <= ax[MW-1:0];
          neg3_q[i][k] <= (x < 0);
          sqr_q[i][k]  <= SQW'(mag3_q[i][k]) * SQW'(mag3_q[i][k]);
        end
        mag4_q[i]     <= mag3_q[i];
        neg4_q[i]     <= neg3_q[i];
        cn_q[i].sum   <= SW'(sqr_q[i][0]) + SW'(sqr_q[i][1]) + SW'(sqr_q[i][2]);
        cn_q[i].mag   <= mag4_q[i];
        cn_q[i].neg   <= neg4_q[i];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_corner
    qcn_norm u_norm (
      .clk    (clk),
      .en     (en),
      .corner (cn_q[g]),
      .nrm    (nrm[g])
    );
  end

  assign normal.n0_x = nrm[0][0];
  assign normal.n0_y = nrm[0][1];
  assign normal.n0_z = nrm[0][2];
  assign normal.n1_x = nrm[1][0];
  assign normal.n1_y = nrm[1][1];
  assign normal.n1_z = nrm[1][2];
  assign normal.n2_x = nrm[2][0];
  assign normal.n2_y = nrm[2][1];
  assign normal.n2_z = nrm[2][2];
  assign normal.n3_x = nrm[3][0];
  assign normal.n3_y = nrm[3][1];
  assign normal.n3_z = nrm[3][2];

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !quad.ready |-> normal.valid)
    else $error("input stalled with no result waiting");

  a_reset_clears_pipe: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("valid bits survived reset");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    normal.valid |-> ($signed(normal.n0_x) <= UNIT && $signed(normal.n0_x) >= -UNIT &&
                      $signed(normal.n3_z) <= UNIT && $signed(normal.n3_z) >= -UNIT))
    else $error("normal component beyond unit length");
`endif

endmodule

@@ sim/quad_corner_normals_core_test.sv @@
`timescale 1ns / 100ps

module quad_corner_normals_core_test;
  import qcn_pkg::*;

  // One quad: corner, then axis x/y/z.
  typedef struct {
    int p [4][3];
  } quad_t;

  // One result: four corner normals, three components each.
  typedef struct {
    logic signed [OW-1:0] n [4][3];
  } normals_t;

  logic clk;
  logic rst;

  qcn_quad_if   quad ();
  qcn_normal_if normal ();

  quad_corner_normals_core DUT (
    .clk    (clk),
    .rst    (rst),
    .quad   (quad.sink),
    .normal (normal.source)
  );

  // Expected normals, oldest first.
  normals_t expected_normals [$];

  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  longint cycles;
  bit timed_out;

  localparam longint CYCLE_LIMIT = 400000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter; a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("timeout after %0d cycles", cycles);
      $display("** quad_corner_normals_core: FAILED **");
      $finish;
    end
  end

  // Floor square root of a sum of squares (fits easily in 64 bits here).
  function automatic longint unsigned floor_root(longint unsigned s);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  // Normal of one corner: cross of the edges to next and prev, scaled to Q1.14.
  function automatic void corner_normal(input quad_t q, input int self, input int nxt,
                                        input int prv,
                                        output logic signed [OW-1:0] res [3]);
    longint u [3];
    longint v [3];
    longint c [3];
    longint unsigned mag [3];
    longint unsigned sum;
    longint unsigned root;
    longint unsigned quo;
    for (int k = 0; k < 3; k++) begin
      u[k] = q.p[nxt][k] - q.p[self][k];
      v[k] = q.p[prv][k] - q.p[self][k];
    end
    c[0] = u[1] * v[2] - u[2] * v[1];
    c[1] = u[2] * v[0] - u[0] * v[2];
    c[2] = u[0] * v[1] - u[1] * v[0];
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (c[k] < 0) ? -c[k] : c[k];
      sum += mag[k] * mag[k];
    end
    root = floor_root(sum);
    for (int k = 0; k < 3; k++) begin
      // |c| < 2^26, so the shifted value stays well inside 64 bits
      quo = (root == 0) ? 0 : (mag[k] << NORMAL_FRACTION) / root;
      res[k] = (c[k] < 0) ? -quo : quo;
    end
  endfunction

  function automatic normals_t quad_normals(quad_t q);
    normals_t r;
    logic signed [OW-1:0] one [3];
    for (int i = 0; i < 4; i++) begin
      corner_normal(q, i, (i + 1) % 4, (i + 3) % 4, one);
      for (int k = 0; k < 3; k++) r.n[i][k] = one[k];
    end
    return r;
  endfunction

  // Send one quad, with a random idle gap first; the expectation is queued on acceptance.
  // valid stays high afterwards so quads can follow back to back.
  task automatic send_quad(quad_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      quad.valid <= 1'b0;
      @(negedge clk);
    end
    quad.valid <= 1'b1;
    quad.c0_x <= q.p[0][0]; quad.c0_y <= q.p[0][1]; quad.c0_z <= q.p[0][2];
    quad.c1_x <= q.p[1][0]; quad.c1_y <= q.p[1][1]; quad.c1_z <= q.p[1][2];
    quad.c2_x <= q.p[2][0]; quad.c2_y <= q.p[2][1]; quad.c2_z <= q.p[2][2];
    quad.c3_x <= q.p[3][0]; quad.c3_y <= q.p[3][1]; quad.c3_z <= q.p[3][2];
    do @(posedge clk); while (!quad.ready);
    expected_normals.insert(expected_normals.size(), quad_normals(q));
    @(negedge clk);
  endtask

  // Receiver: random stalls, changed at the falling edge.
  always @(negedge clk) begin
    if (rst) normal.ready <= 1'b0;
    else normal.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: every accepted normal transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    normals_t want;
    logic signed [OW-1:0] got [4][3];
    if (!rst && normal.valid && normal.ready) begin
      got = '{'{normal.n0_x, normal.n0_y, normal.n0_z},
              '{normal.n1_x, normal.n1_y, normal.n1_z},
              '{normal.n2_x, normal.n2_y, normal.n2_z},
              '{normal.n3_x, normal.n3_y, normal.n3_z}};
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected normal transaction at cycle %0d", cycles);
      end else begin
        want = expected_normals.pop_front();
        for (int i = 0; i < 4; i++)
          for (int k = 0; k < 3; k++)
            if (got[i][k] !== want.n[i][k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("corner %0d axis %0d: expected %0d, got %0d",
                         i, k, want.n[i][k], got[i][k]);
            end
      end
    end
  end

  function automatic int rand_coord();
    return $signed(12'($urandom));
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(3))
      0: return -2048;
      1: return 2047;
      2: return 0;
      default: return rand_coord();
    endcase
  endfunction

  function automatic quad_t fill_quad(int v);
    quad_t q;
    for (int i = 0; i < 4; i++) for (int k = 0; k < 3; k++) q.p[i][k] = v;
    return q;
  endfunction

  // Directed: extremes, degenerate and collinear corners, axis-aligned squares.
  task automatic test_directed();
    quad_t q;
    send_quad(fill_quad(0));
    send_quad(fill_quad(-2048));
    send_quad(fill_quad(2047));
    // unit square in xy: normals along +z
    q = fill_quad(0);
    q.p[1][0] = 1; q.p[2][0] = 1; q.p[2][1] = 1; q.p[3][1] = 1;
    send_quad(q);
    // largest square in yz, reversed winding in xz
    q = fill_quad(-2048);
    q.p[1][1] = 2047; q.p[2][1] = 2047; q.p[2][2] = 2047; q.p[3][2] = 2047;
    send_quad(q);
    q = fill_quad(2047);
    q.p[1][2] = -2048; q.p[2][2] = -2048; q.p[2][0] = -2048; q.p[3][0] = -2048;
    send_quad(q);
    // collinear corners: zero cross products
    for (int i = 0; i < 4; i++) for (int k = 0; k < 3; k++) q.p[i][k] = i * 100 - 2000;
    send_quad(q);
    // two corners coincide
    q = fill_quad(0);
    q.p[1][0] = 2047; q.p[2][1] = -2048;
    send_quad(q);
    // extreme spread, diagonal quads, equal components
    for (int j = 0; j < 12; j++) begin
      for (int i = 0; i < 4; i++) for (int k = 0; k < 3; k++) q.p[i][k] = pick_extreme();
      send_quad(q);
    end
    q = fill_quad(0);
    q.p[1] = '{2047, -2048, 0}; q.p[2] = '{2047, 2047, -2048}; q.p[3] = '{-2048, 2047, 2047};
    send_quad(q);
  endtask

  // Random quads: mostly full-range, some small planar ones, some near-degenerate.
  task automatic test_random(int count);
    quad_t q;
    int base;
    for (int j = 0; j < count; j++) begin
      case ($urandom_range(9))
        0, 1: begin
          base = $urandom_range(40) - 20;
          for (int i = 0; i < 4; i++) begin
            q.p[i][0] = $urandom_range(16) - 8;
            q.p[i][1] = $urandom_range(16) - 8;
            q.p[i][2] = base;
          end
        end
        2: begin
          q = fill_quad(rand_coord());
          q.p[$urandom_range(3)][$urandom_range(2)] = rand_coord();
        end
        3:
          for (int i = 0; i < 4; i++) for (int k = 0; k < 3; k++) q.p[i][k] = pick_extreme();
        default:
          for (int i = 0; i < 4; i++) for (int k = 0; k < 3; k++) q.p[i][k] = rand_coord();
      endcase
      send_quad(q);
    end
  endtask

  task automatic set_idling(int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
  endtask

  initial begin
    int drain;
    rst = 1'b1;
    cycles = 0;
    timed_out = 1'b0;
    mismatches = 0;
    set_idling(0, 0);
    quad.valid = 1'b0;
    {quad.c0_x, quad.c0_y, quad.c0_z, quad.c1_x, quad.c1_y, quad.c1_z} = '0;
    {quad.c2_x, quad.c2_y, quad.c2_z, quad.c3_x, quad.c3_y, quad.c3_z} = '0;
    normal.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    // idling phases: none, sender only, receiver only, both
    test_random(350);
    set_idling(52, 0);
    test_random(350);
    set_idling(0, 52);
    test_random(350);
    set_idling(30, 30);
    test_random(375);
    quad.valid <= 1'b0;

    // drain: wait for every prediction, then allow for the pipeline depth
    while (expected_normals.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 2 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    if (mismatches == 0) begin
      $display("** quad_corner_normals_core: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** quad_corner_normals_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/qcn_pkg.sv
sv/qcn_quad_if.sv
sv/qcn_normal_if.sv
sv/qcn_norm.sv
sv/quad_corner_normals_core.sv
sim/quad_corner_normals_core_test.sv
